FILE: rtl/hbfc_pkg.sv
`timescale 1ns / 1ps

package hbfc_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int ANGLE_WIDTH     = 40;

    // packed word widths, padded up to whole bytes
    localparam int IN_BITS     = 46 + ANGLE_WIDTH;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 26 + ANGLE_WIDTH;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RPM   = 1'd1;

    localparam logic [3:0]  LEVEL_RESET = 4'd10;
    localparam logic [13:0] RPM_RESET   = 14'd8820;

    localparam logic [1:0] MODE_STOP   = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd2;

    localparam logic [1:0] SHOT_IDLE  = 2'd0;
    localparam logic [1:0] SHOT_ARMED = 2'd1;
    localparam logic [1:0] SHOT_FIRED = 2'd2;

    localparam logic [2:0] FS_CODE_RESET  = 3'd0;
    localparam logic [2:0] FS_CODE_HOMING = 3'd1;
    localparam logic [2:0] FS_CODE_SETTLE = 3'd2;
    localparam logic [2:0] FS_CODE_READY  = 3'd3;
    localparam logic [2:0] FS_CODE_FIRING = 3'd4;

    localparam logic [19:0] HEAT_MAX   = 20'd1048575;
    localparam logic [19:0] HEAT_SHOT  = 20'd100000;

    // angles in Q32 radians, rounded to the working fraction width
    localparam logic [63:0] PILL_Q32      = 64'd10194739610;
    localparam logic [63:0] HOME_STEP_Q32 = 64'd128849019;
    localparam logic [63:0] REV_STEP_Q32  = 64'd257698038;

    function automatic logic [ANGLE_WIDTH-1:0] to_q(input logic [63:0] q32);
        logic [63:0] s;
        s = (q32 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS);
        return s[ANGLE_WIDTH-1:0];
    endfunction

    localparam logic [ANGLE_WIDTH-1:0] PILL_STEP    = to_q(PILL_Q32);
    localparam logic [ANGLE_WIDTH-1:0] QUARTER_STEP = to_q(PILL_Q32 >> 2);
    localparam logic [ANGLE_WIDTH-1:0] HOME_STEP    = to_q(HOME_STEP_Q32);
    localparam logic [ANGLE_WIDTH-1:0] REV_STEP     = to_q(REV_STEP_Q32);

endpackage

FILE: rtl/heat_budget_fire_controller.sv
`timescale 1ns / 1ps

// heat budget fire controller, one word per 1 ms control tick
// slave channel (i_s_*): one tick word with mode, fire stick, limit switch,
// wheel speeds, measured feeder angle and the online / ready flags
// master channel (o_m_*): one result word per tick with the angle target,
// limit profile, heat level, shot status and fire state
// configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_addr
// (0 robot level, 1 wheel target rpm); write only while no word is in flight
// pipeline: two register stages (input register, result register); a word
// held in the input register shows on o_m_tvalid from the result register
// throughput: one word per cycle while i_m_tready is high; the whole tick
// update is a single pass of compare and add logic between the two
// registers, state is written back at the same edge as the result
// stall: when the receiver holds i_m_tready low the result stays put, one
// more word is held in the input register, then o_s_tready drops
// reset: i_rst_n low at an edge clears both stages, the heat count, the
// angle target and the state machines, and restores level 10 and 8820 rpm
module heat_budget_fire_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hbfc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [hbfc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // fire_mode, fire_stick, limit_switch, right_wheel_rpm, left_wheel_rpm,
    // feeder_angle, feeder_online, wheels_ready, zero pad
    input  logic [hbfc_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // angle_target, limit_profile, heat_level, shot_status, fire_state,
    // zero pad
    output logic [hbfc_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import hbfc_pkg::*;

    typedef enum logic [4:0] {
        ST_RESET  = 5'b00001,
        ST_HOMING = 5'b00010,
        ST_SETTLE = 5'b00100,
        ST_READY  = 5'b01000,
        ST_FIRING = 5'b10000
    } t_fire_state;

    typedef enum logic [1:0] {
        DET_START = 2'd0,
        DET_WAIT  = 2'd1,
        DET_ARMED = 2'd2,
        DET_FIRED = 2'd3
    } t_detect;

    localparam int AW = ANGLE_WIDTH;

    logic [3:0]           r_level;
    logic [13:0]          r_rpm;
    logic                 r_in_valid;
    logic [IN_BITS-1:0]   r_in_data;
    logic                 r_out_valid;
    logic [OUT_BITS-1:0]  r_out_data;

    t_fire_state          r_state, n_state;
    logic [6:0]           r_wait, n_wait;
    t_detect              r_det, n_det;
    logic [19:0]          r_heat, n_heat;
    logic [AW-1:0]        r_target, n_target;
    logic                 r_profile, n_profile;
    logic [OUT_BITS-1:0]  n_out_data;

    logic advance;
    logic step;

    assign advance    = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, r_out_data};

    // unpack the held word
    logic [1:0]         w_mode;
    logic signed [10:0] w_stick;
    logic               w_sw;
    logic signed [16:0] w_rr, w_lr, w_t;
    logic [AW-1:0]      w_meas;
    logic               w_online, w_ready;

    assign w_mode   = r_in_data[1:0];
    assign w_stick  = r_in_data[12:2];
    assign w_sw     = r_in_data[13];
    assign w_rr     = {{2{r_in_data[28]}}, r_in_data[28:14]};
    assign w_lr     = {{2{r_in_data[43]}}, r_in_data[43:29]};
    assign w_meas   = r_in_data[44 +: AW];
    assign w_online = r_in_data[44 + AW];
    assign w_ready  = r_in_data[45 + AW];
    assign w_t      = {3'b000, r_rpm};

    // level-dependent figures
    logic [3:0]  w_lvl;
    logic [7:0]  w_rate;
    logic [6:0]  w_margin;
    logic [19:0] w_limit;

    always_comb begin
        if (r_level == 4'd0) begin
            w_lvl = 4'd1;
        end else if (r_level > 4'd10) begin
            w_lvl = 4'd10;
        end else begin
            w_lvl = r_level;
        end
        if (w_lvl == 4'd1) begin
            w_rate = 8'd70;
        end else if (w_lvl == 4'd10) begin
            w_rate = 8'd220;
        end else begin
            w_rate = 8'({4'd0, w_lvl} << 4) + 8'd44;
        end
        w_margin = 7'd108 - 7'({3'd0, w_lvl} << 3);
        w_limit  = 20'({16'd0, w_lvl} - 20'd1) * 20'd40000;
    end

    logic w_fire_req, w_rev_req;
    assign w_fire_req = w_stick > 11'sd500;
    assign w_rev_req  = w_stick < -11'sd500;

    logic [20:0] w_heat_add;
    logic [19:0] w_heat_shot;
    logic        w_budget;
    logic [2:0]  w_state_code;
    logic [1:0]  w_shot;

    always_comb begin
        n_state   = r_state;
        n_det     = r_det;
        n_target  = r_target;
        n_profile = r_profile;
        n_wait    = (r_wait != 7'd0) ? r_wait - 7'd1 : 7'd0;
        w_heat_shot = r_heat;
        w_heat_add  = {1'b0, r_heat} + {1'b0, HEAT_SHOT};

        case (r_det)
            DET_START: begin
                n_det = DET_WAIT;
            end
            DET_WAIT: begin
                if (w_rr < 17'sd540 - w_t && w_lr > w_t - 17'sd540) begin
                    n_det = DET_ARMED;
                end
            end
            DET_ARMED: begin
                if (w_mode == MODE_STOP) begin
                    n_det = DET_WAIT;
                end else if (w_rr > 17'sd720 - w_t && w_rr < 17'sd2700 - w_t &&
                             w_lr < w_t - 17'sd720 && w_lr > w_t - 17'sd2700) begin
                    // speed dip on both wheels: a pellet went through
                    w_heat_shot = w_heat_add[20] ? HEAT_MAX : w_heat_add[19:0];
                    n_target    = w_meas;
                    n_det       = DET_FIRED;
                end
            end
            default: begin
            end
        endcase

        n_heat   = (w_heat_shot < {12'd0, w_rate}) ? 20'd0
                                                   : w_heat_shot - {12'd0, w_rate};
        w_budget = n_heat <= w_limit;

        if (w_online) begin
            case (r_state)
                ST_RESET: begin
                    if (n_wait == 7'd0 && w_ready) begin
                        n_state = w_sw ? ST_HOMING : ST_READY;
                        n_wait  = 7'd100;
                    end
                end
                ST_HOMING: begin
                    if (n_wait == 7'd0) begin
                        if (!w_sw) begin
                            n_wait  = 7'd2;
                            n_state = ST_SETTLE;
                        end else begin
                            n_target = n_target - HOME_STEP;
                            n_wait   = 7'd5;
                        end
                    end
                end
                ST_SETTLE: begin
                    if (n_wait == 7'd0) begin
                        n_target = n_target - QUARTER_STEP;
                        n_wait   = 7'd100;
                        n_state  = ST_READY;
                    end
                end
                ST_READY: begin
                    if (n_wait == 7'd0 && w_mode == MODE_SINGLE) begin
                        if (w_fire_req) begin
                            if (w_budget && n_det == DET_ARMED) begin
                                n_target  = n_target - PILL_STEP;
                                n_profile = 1'b0;
                                n_state   = ST_FIRING;
                                n_wait    = w_margin;
                            end else if (n_det == DET_FIRED) begin
                                n_det  = DET_WAIT;
                                n_wait = w_margin;
                            end else begin
                                n_wait = 7'd20;
                            end
                        end else if (w_rev_req) begin
                            n_profile = 1'b1;
                            n_target  = n_target + REV_STEP;
                            n_wait    = 7'd10;
                        end else begin
                            n_wait = 7'd10;
                        end
                    end
                end
                ST_FIRING: begin
                    if (!w_budget) begin
                        n_target = w_meas;
                    end
                    if (n_wait == 7'd0) begin
                        if (!w_fire_req && !w_rev_req) begin
                            n_det   = DET_WAIT;
                            n_wait  = w_margin;
                            n_state = ST_READY;
                        end else begin
                            n_wait = 7'd10;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        case (n_state)
            ST_RESET:  w_state_code = FS_CODE_RESET;
            ST_HOMING: w_state_code = FS_CODE_HOMING;
            ST_SETTLE: w_state_code = FS_CODE_SETTLE;
            ST_READY:  w_state_code = FS_CODE_READY;
            ST_FIRING: w_state_code = FS_CODE_FIRING;
            default:   w_state_code = FS_CODE_RESET;
        endcase

        case (n_det)
            DET_ARMED: w_shot = SHOT_ARMED;
            DET_FIRED: w_shot = SHOT_FIRED;
            default:   w_shot = SHOT_IDLE;
        endcase

        n_out_data = {w_state_code, w_shot, n_heat, n_profile, n_target};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= LEVEL_RESET;
            r_rpm       <= RPM_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_RESET;
            r_wait      <= 7'd0;
            r_det       <= DET_START;
            r_heat      <= 20'd0;
            r_target    <= '0;
            r_profile   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_LEVEL: r_level <= i_cfg_wdata[3:0];
                    CFG_RPM:   r_rpm   <= i_cfg_wdata[13:0];
                    default: begin
                    end
                endcase
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_state   <= n_state;
                r_wait    <= n_wait;
                r_det     <= n_det;
                r_heat    <= n_heat;
                r_target  <= n_target;
                r_profile <= n_profile;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data <= i_s_tdata[IN_BITS-1:0];
        end
        if (step) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

FILE: rtl/hbfc_checker.sv
`timescale 1ns / 1ps

module hbfc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tready,
    input logic                              i_m_tvalid,
    input logic                              i_m_tready,
    input logic [hbfc_pkg::OUT_TDATA_W-1:0]  i_m_tdata
);
    import hbfc_pkg::*;

    localparam int ST_LSB   = ANGLE_WIDTH + 23;
    localparam int SHOT_LSB = ANGLE_WIDTH + 21;

    // a stalled result word stays
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> $stable(i_m_tdata))
        else $error("result word changed while stalled");

    // input side only backs up behind a full, stalled output
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_s_tready |-> i_m_tvalid && !i_m_tready)
        else $error("input stalled without output back-pressure");

    a_state_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[ST_LSB +: 3] <= FS_CODE_FIRING)
        else $error("fire state code out of range");

    a_shot_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[SHOT_LSB +: 2] != 2'd3)
        else $error("shot status code out of range");

endmodule

bind heat_budget_fire_controller hbfc_checker u_hbfc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

FILE: bench/heat_budget_fire_controller_test.sv
`timescale 1ns / 1ps

module heat_budget_fire_controller_test;

    import hbfc_pkg::*;

    localparam logic [1:0] MODE_BURST = 2'd1;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int HEAT_TOP  = 1048575;
    localparam int SHOT_HEAT = 100000;

    localparam logic [ANGLE_WIDTH-1:0] ANGLE_MIN = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_MAX = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};

    // step sizes in q32 radians, rounded to nearest at the working fraction
    localparam logic [63:0] PELLET_RAD_Q32 = 64'd10194739610;
    localparam logic [63:0] HOMING_RAD_Q32 = 64'd128849019;
    localparam logic [63:0] BACKUP_RAD_Q32 = 64'd257698038;
    localparam logic [63:0] ROUND_HALF     = 64'd1 << (31 - ANGLE_FRAC_BITS);
    localparam int          Q_SHIFT        = 32 - ANGLE_FRAC_BITS;
    localparam logic [63:0] PELLET_Q    = (PELLET_RAD_Q32 + ROUND_HALF) >> Q_SHIFT;
    localparam logic [63:0] QUARTER_Q   = ((PELLET_RAD_Q32 >> 2) + ROUND_HALF) >> Q_SHIFT;
    localparam logic [63:0] HOMING_Q    = (HOMING_RAD_Q32 + ROUND_HALF) >> Q_SHIFT;
    localparam logic [63:0] BACKUP_Q    = (BACKUP_RAD_Q32 + ROUND_HALF) >> Q_SHIFT;

    typedef enum logic [1:0] {
        DET_START   = 2'd0,
        DET_SPIN_UP = 2'd1,
        DET_ARMED   = 2'd2,
        DET_FIRED   = 2'd3
    } t_detect;

    typedef struct packed {
        logic [IN_TDATA_W-IN_BITS-1:0] pad;
        logic                          wheels_ready;
        logic                          feeder_online;
        logic [ANGLE_WIDTH-1:0]        feeder_angle;
        logic [14:0]                   left_rpm;
        logic [14:0]                   right_rpm;
        logic                          limit_switch;
        logic [10:0]                   fire_stick;
        logic [1:0]                    fire_mode;
    } t_tick_word;

    typedef struct packed {
        logic [OUT_TDATA_W-OUT_BITS-1:0] pad;
        logic [2:0]                      fire_state;
        logic [1:0]                      shot_status;
        logic [19:0]                     heat_level;
        logic                            limit_profile;
        logic [ANGLE_WIDTH-1:0]          angle_target;
    } t_outcome_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    // fire_mode, fire_stick, limit_switch, right_wheel_rpm, left_wheel_rpm,
    // feeder_angle, feeder_online, wheels_ready, zero pad
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b1;
    // angle_target, limit_profile, heat_level, shot_status, fire_state, zero pad
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    heat_budget_fire_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // controller state as the bench sees it, starting from reset
    logic [3:0]             level_reg       = 4'd10;
    int                     wheel_rpm       = 8820;
    logic [2:0]             fire_step       = FS_CODE_RESET;
    int                     hold_ticks      = 0;
    t_detect                shot_detect     = DET_START;
    int                     heat_tally      = 0;
    logic [ANGLE_WIDTH-1:0] aim             = '0;
    logic                   reverse_profile = 1'b0;

    t_outcome_word pending_outcomes[$];
    int            mismatches = 0;
    int            gap_pct    = 0;
    int            stall_pct  = 0;

    function automatic int clamped_level();
        if (level_reg < 4'd1) return 1;
        if (level_reg > 4'd10) return 10;
        return int'(level_reg);
    endfunction

    function automatic bit heat_allows_shot();
        return heat_tally <= (60 + 40 * clamped_level() - 100) * 1000;
    endfunction

    function automatic t_outcome_word advance_controller(input t_tick_word w);
        t_outcome_word r;
        int lvl, spd, rr, lr, stick, margin, rate;
        lvl    = clamped_level();
        spd    = wheel_rpm;
        rr     = $signed(w.right_rpm);
        lr     = $signed(w.left_rpm);
        stick  = $signed(w.fire_stick);
        margin = 108 - 8 * lvl;
        if (lvl == 1) rate = 70;
        else if (lvl == 10) rate = 220;
        else rate = 16 * lvl + 44;

        if (hold_ticks > 0) hold_ticks--;

        case (shot_detect)
            DET_START: shot_detect = DET_SPIN_UP;
            DET_SPIN_UP: begin
                if (rr < -spd + 540 && lr > spd - 540) shot_detect = DET_ARMED;
            end
            DET_ARMED: begin
                if (w.fire_mode == MODE_STOP) begin
                    shot_detect = DET_SPIN_UP;
                end else if (rr > -spd + 720 && rr < -spd + 2700 &&
                             lr < spd - 720 && lr > spd - 2700) begin
                    // speed dip on both wheels: a pellet has left
                    heat_tally  = (heat_tally > HEAT_TOP - SHOT_HEAT) ? HEAT_TOP
                                                                      : heat_tally + SHOT_HEAT;
                    aim         = w.feeder_angle;
                    shot_detect = DET_FIRED;
                end
            end
            default: ;
        endcase

        heat_tally = (heat_tally < rate) ? 0 : heat_tally - rate;

        if (w.feeder_online) begin
            case (fire_step)
                FS_CODE_RESET: begin
                    if (hold_ticks == 0 && w.wheels_ready) begin
                        fire_step  = w.limit_switch ? FS_CODE_HOMING : FS_CODE_READY;
                        hold_ticks = 100;
                    end
                end
                FS_CODE_HOMING: begin
                    if (hold_ticks == 0) begin
                        if (!w.limit_switch) begin
                            hold_ticks = 2;
                            fire_step  = FS_CODE_SETTLE;
                        end else begin
                            aim        = aim - HOMING_Q[ANGLE_WIDTH-1:0];
                            hold_ticks = 5;
                        end
                    end
                end
                FS_CODE_SETTLE: begin
                    if (hold_ticks == 0) begin
                        aim        = aim - QUARTER_Q[ANGLE_WIDTH-1:0];
                        hold_ticks = 100;
                        fire_step  = FS_CODE_READY;
                    end
                end
                FS_CODE_READY: begin
                    if (hold_ticks == 0 && w.fire_mode == MODE_SINGLE) begin
                        if (stick > 500) begin
                            if (heat_allows_shot() && shot_detect == DET_ARMED) begin
                                aim             = aim - PELLET_Q[ANGLE_WIDTH-1:0];
                                reverse_profile = 1'b0;
                                fire_step       = FS_CODE_FIRING;
                                hold_ticks      = margin;
                            end else if (shot_detect == DET_FIRED) begin
                                shot_detect = DET_SPIN_UP;
                                hold_ticks  = margin;
                            end else begin
                                hold_ticks = 20;
                            end
                        end else if (stick < -500) begin
                            reverse_profile = 1'b1;
                            aim             = aim + BACKUP_Q[ANGLE_WIDTH-1:0];
                            hold_ticks      = 10;
                        end else begin
                            hold_ticks = 10;
                        end
                    end
                end
                FS_CODE_FIRING: begin
                    // out of budget: the target follows the measured angle
                    if (!heat_allows_shot()) aim = w.feeder_angle;
                    if (hold_ticks == 0) begin
                        if (stick >= -500 && stick <= 500) begin
                            shot_detect = DET_SPIN_UP;
                            hold_ticks  = margin;
                            fire_step   = FS_CODE_READY;
                        end else begin
                            hold_ticks = 10;
                        end
                    end
                end
                default: ;
            endcase
        end

        r               = '0;
        r.angle_target  = aim;
        r.limit_profile = reverse_profile;
        r.heat_level    = heat_tally[19:0];
        r.shot_status   = (shot_detect == DET_ARMED) ? SHOT_ARMED :
                          (shot_detect == DET_FIRED) ? SHOT_FIRED : SHOT_IDLE;
        r.fire_state    = fire_step;
        return r;
    endfunction

    function automatic logic [14:0] rpm_field(input int v);
        int c;
        c = (v > 9000) ? 9000 : (v < -9000) ? -9000 : v;
        return c[14:0];
    endfunction

    function automatic t_tick_word tick_of(input logic [1:0] mode, input int stick,
                                           input logic sw, input int rr, input int lr,
                                           input logic [ANGLE_WIDTH-1:0] angle,
                                           input logic online, input logic ready);
        t_tick_word w;
        w               = '0;
        w.fire_mode     = mode;
        w.fire_stick    = stick[10:0];
        w.limit_switch  = sw;
        w.right_rpm     = rpm_field(rr);
        w.left_rpm      = rpm_field(lr);
        w.feeder_angle  = angle;
        w.feeder_online = online;
        w.wheels_ready  = ready;
        return w;
    endfunction

    // plausible shooter traffic: wheels mostly at speed, with random speed dips
    function automatic t_tick_word shooter_tick();
        t_tick_word w;
        int pick, spd, v;
        logic [63:0] noise;
        spd   = wheel_rpm;
        noise = {$urandom, $urandom};
        w     = '0;

        pick = $urandom_range(99);
        w.fire_mode = (pick < 80) ? MODE_SINGLE : (pick < 88) ? MODE_BURST :
                      (pick < 94) ? MODE_STOP : MODE_SPARE;

        pick = $urandom_range(99);
        if (pick < 55) v = $urandom_range(1000, 501);
        else if (pick < 80) v = int'($urandom_range(1000)) - 500;
        else if (pick < 90) v = -int'($urandom_range(1000, 501));
        else begin
            case ($urandom_range(3))
                0: v = 500;
                1: v = 501;
                2: v = -500;
                default: v = -501;
            endcase
        end
        w.fire_stick = v[10:0];

        if (fire_step == FS_CODE_HOMING) w.limit_switch = ($urandom_range(99) >= 15);
        else w.limit_switch = ($urandom_range(99) >= 85);

        pick = $urandom_range(99);
        if (pick < 70) begin
            w.right_rpm = rpm_field(-spd - int'($urandom_range(500)));
            w.left_rpm  = rpm_field(spd + int'($urandom_range(500)));
        end else if (pick < 90) begin
            w.right_rpm = rpm_field(-spd + int'($urandom_range(2699, 721)));
            w.left_rpm  = rpm_field(spd - int'($urandom_range(2699, 721)));
        end else begin
            w.right_rpm = rpm_field(int'($urandom_range(18000)) - 9000);
            w.left_rpm  = rpm_field(int'($urandom_range(18000)) - 9000);
        end

        pick = $urandom_range(99);
        if (pick < 55) w.feeder_angle = aim ^ {{(ANGLE_WIDTH-16){1'b0}}, noise[15:0]};
        else if (pick < 90) w.feeder_angle = noise[ANGLE_WIDTH-1:0];
        else if (pick < 94) w.feeder_angle = ANGLE_MIN;
        else if (pick < 98) w.feeder_angle = ANGLE_MAX;
        else w.feeder_angle = '0;

        w.feeder_online = ($urandom_range(99) >= 4);
        w.wheels_ready  = ($urandom_range(99) >= 5);
        return w;
    endfunction

    function automatic t_tick_word noise_tick();
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        return tick_of(2'($urandom_range(3)), int'($urandom_range(2000)) - 1000,
                       1'($urandom_range(1)), int'($urandom_range(18000)) - 9000,
                       int'($urandom_range(18000)) - 9000, noise[ANGLE_WIDTH-1:0],
                       1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    task automatic send_tick(input t_tick_word w);
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= w;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_outcomes.push_back(advance_controller(w));
    endtask

    task automatic drain_words();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [CFG_ADDR_W-1:0] addr, input int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value[CFG_DATA_W-1:0];
        if (addr == CFG_LEVEL) level_reg = value[3:0];
        else wheel_rpm = value & 32'h3FFF;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_ticks(input int count, input int noise_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < noise_pct) send_tick(noise_tick());
            else send_tick(shooter_tick());
        end
    endtask

    // field extremes, detector thresholds and every mode, machine held in reset until the last tick
    task automatic test_extremes();
        gap_pct   = 0;
        stall_pct = 0;
        send_tick(tick_of(MODE_STOP, 0, 1'b0, 0, 0, '0, 1'b1, 1'b0));
        // exactly on the spin-up thresholds: not yet armed
        send_tick(tick_of(MODE_SINGLE, 0, 1'b0, -8280, 8281, '0, 1'b1, 1'b0));
        send_tick(tick_of(MODE_SINGLE, 0, 1'b0, -8281, 8280, '0, 1'b1, 1'b0));
        send_tick(tick_of(MODE_SINGLE, 0, 1'b0, -9000, 9000, ANGLE_MAX, 1'b1, 1'b0));
        send_tick(tick_of(MODE_STOP, 1000, 1'b0, -9000, 9000, '0, 1'b1, 1'b0));
        send_tick(tick_of(MODE_BURST, 0, 1'b0, -9000, 9000, '0, 1'b1, 1'b0));
        // on the dip window edges: no shot
        send_tick(tick_of(MODE_SINGLE, 0, 1'b0, -8100, 8099, '0, 1'b1, 1'b0));
        send_tick(tick_of(MODE_SINGLE, 0, 1'b0, -8099, 8100, '0, 1'b1, 1'b0));
        send_tick(tick_of(MODE_SINGLE, 0, 1'b0, -6120, 6121, '0, 1'b1, 1'b0));
        send_tick(tick_of(MODE_SINGLE, 0, 1'b0, -6121, 6120, '0, 1'b1, 1'b0));
        // spare mode still counts as a shot
        send_tick(tick_of(MODE_SPARE, 0, 1'b0, -8099, 8099, ANGLE_MAX, 1'b1, 1'b0));
        send_tick(tick_of(MODE_BURST, 1000, 1'b1, 9000, -9000, ANGLE_MIN, 1'b1, 1'b0));
        send_tick(tick_of(MODE_SINGLE, -1000, 1'b1, -9000, 9000, ANGLE_MIN, 1'b0, 1'b1));
        send_tick(tick_of(MODE_SINGLE, 500, 1'b0, 9000, 9000, '0, 1'b1, 1'b0));
        send_tick(tick_of(MODE_SINGLE, -500, 1'b0, -9000, -9000, '0, 1'b1, 1'b0));
        send_tick(tick_of(MODE_SINGLE, 501, 1'b1, 0, 0, ANGLE_MAX, 1'b0, 1'b0));
        send_tick(tick_of(MODE_SINGLE, -501, 1'b0, 0, 0, ANGLE_MIN, 1'b1, 1'b0));
        send_tick(tick_of(MODE_SPARE, 1000, 1'b1, -9000, 9000, ANGLE_MAX, 1'b0, 1'b1));
        // ready with the switch open: into homing
        send_tick(tick_of(MODE_SINGLE, 0, 1'b1, -9000, 9000, '0, 1'b1, 1'b1));
        drain_words();
    endtask

    task automatic test_homing_and_single_fire();
        write_setting(CFG_LEVEL, 10);
        write_setting(CFG_RPM, 8820);
        gap_pct   = 0;
        stall_pct = 0;
        run_ticks(450, 3);
        drain_words();
    endtask

    // level 1 has no spare budget, so repeated shots drive heat to saturation
    task automatic test_heat_saturation();
        write_setting(CFG_LEVEL, 1);
        write_setting(CFG_RPM, 9000);
        gap_pct   = 50;
        stall_pct = 0;
        run_ticks(350, 3);
        drain_words();
    endtask

    task automatic test_mid_levels();
        gap_pct   = 0;
        stall_pct = 50;
        write_setting(CFG_LEVEL, 4);
        write_setting(CFG_RPM, $urandom_range(9000));
        run_ticks(200, 5);
        drain_words();
        write_setting(CFG_LEVEL, 7);
        write_setting(CFG_RPM, $urandom_range(9000));
        run_ticks(200, 5);
        drain_words();
    endtask

    task automatic test_level_clamping();
        gap_pct   = 6;
        stall_pct = 6;
        write_setting(CFG_LEVEL, 0);
        write_setting(CFG_RPM, 0);
        run_ticks(150, 5);
        drain_words();
        write_setting(CFG_LEVEL, 15);
        write_setting(CFG_RPM, 9000);
        run_ticks(150, 5);
        drain_words();
    endtask

    task automatic test_random_traffic();
        int gaps[4]   = '{0, 50, 0, 6};
        int stalls[4] = '{0, 0, 50, 6};
        for (int p = 0; p < 4; p++) begin
            gap_pct   = gaps[p];
            stall_pct = stalls[p];
            write_setting(CFG_LEVEL, $urandom_range(15));
            write_setting(CFG_RPM, $urandom_range(9000));
            run_ticks(65, 40);
            drain_words();
        end
    endtask

    always @(negedge i_clk) i_m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin : score_outcome
        t_outcome_word got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", o_m_tdata);
            end else begin
                want = pending_outcomes.pop_front();
                if (got.angle_target !== want.angle_target ||
                    got.limit_profile !== want.limit_profile ||
                    got.heat_level !== want.heat_level ||
                    got.shot_status !== want.shot_status ||
                    got.fire_state !== want.fire_state) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: angle %h/%h profile %b/%b heat %0d/%0d",
                                 want.angle_target, got.angle_target,
                                 want.limit_profile, got.limit_profile,
                                 want.heat_level, got.heat_level,
                                 " shot %0d/%0d state %0d/%0d (expected/actual)",
                                 want.shot_status, got.shot_status,
                                 want.fire_state, got.fire_state);
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("[heat_budget_fire_controller] ERROR");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_homing_and_single_fire();
        test_heat_saturation();
        test_mid_levels();
        test_level_clamping();
        test_random_traffic();

        drain_words();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("[heat_budget_fire_controller] OK");
        end else begin
            $display("[heat_budget_fire_controller] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/hbfc_pkg.sv
rtl/heat_budget_fire_controller.sv
rtl/hbfc_checker.sv
bench/heat_budget_fire_controller_test.sv
